### hw/rtl/rtes_pkg.sv
// Shared widths, field codes and constants of the rate-table event selector.
package rtes_pkg;

   // Fixed field and arithmetic widths
   localparam int SUM_W  = 48;   // running total of all rates
   localparam int FRAC_W = 17;   // selection fraction
   localparam int PROD_W = 65;   // total * fraction
   localparam int CNT_W  = 5;    // step counter of the product unit

   // Fraction scale: hundred-thousandths
   localparam logic [FRAC_W-1:0] FRAC_SCALE = 17'd100000;

   // Command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SELECT = 1'b1;

   // Species codes
   localparam logic SPECIES_INT = 1'b0;
   localparam logic SPECIES_VAC = 1'b1;

   // Result kind codes
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_INT  = 2'd1;
   localparam logic [1:0] KIND_VAC  = 2'd2;

endpackage

### hw/rtl/rtes_req_if.sv
// Request channel of the event selector: valid/ready plus one command item.
interface rtes_req_if import rtes_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              command;
   logic [5:0]        site_x;
   logic [5:0]        site_y;
   logic [1:0]        direction;
   logic              species;
   logic [31:0]       rate_value;
   logic [FRAC_W-1:0] random_fraction;

   modport source (output valid, command, site_x, site_y, direction, species,
                   rate_value, random_fraction, input ready);
   modport sink   (input valid, command, site_x, site_y, direction, species,
                   rate_value, random_fraction, output ready);
endinterface

### hw/rtl/rtes_rsp_if.sv
// Response channel of the event selector: valid/ready plus one result item.
interface rtes_rsp_if import rtes_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       hop_kind;
   logic [5:0]       hop_x;
   logic [5:0]       hop_y;
   logic [1:0]       hop_direction;
   logic [SUM_W-1:0] total_rate;

   modport source (output valid, hop_kind, hop_x, hop_y, hop_direction, total_rate,
                   input ready);
   modport sink   (input valid, hop_kind, hop_x, hop_y, hop_direction, total_rate,
                   output ready);
endinterface

### hw/rtl/rtes_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rtes_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/rtes_thresh.sv
// Product unit: total * fraction by shift-add multiply, one fraction bit a cycle.
// The scan compares its sum scaled by 100000 against this product, so
// floor(total * fraction / 100000) never has to be formed.
module rtes_thresh import rtes_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  total,
   input  logic [FRAC_W-1:0] frac,
   output logic              done,
   output logic [PROD_W-1:0] product
);

   localparam logic T_IDLE = 1'b0;
   localparam logic T_MUL  = 1'b1;

   logic              state_ff, state_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SUM_W-1:0]  mcand_ff, mcand_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;

   logic [PROD_W-1:0] mul_sum;

   // Shared datapath: one add per multiply step, fraction MSB first
   always_comb begin
      mul_sum = {prod_ff[PROD_W-2:0], 1'b0}
              + (frac_ff[FRAC_W-1] ? PROD_W'(mcand_ff) : '0);
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      frac_in  = frac_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (start) begin
               prod_in  = '0;
               mcand_in = total;
               frac_in  = frac;
               count_in = CNT_W'(FRAC_W - 1);
               state_in = T_MUL;
            end
         end
         T_MUL: begin
            prod_in = mul_sum;
            frac_in = {frac_ff[FRAC_W-2:0], 1'b0};
            if (count_ff == '0) begin
               done_in  = 1'b1;
               state_in = T_IDLE;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
      frac_ff  <= frac_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

### hw/rtl/rate_table_event_selector.sv
// Top level of the rate-table event selector (kinetic Monte Carlo hop picker).
//
// Items arrive on req_ch (valid/ready). A write item (command 0) replaces one
// interstitial or vacancy rate and adjusts the running total; a select item
// (command 1) scans both tables from the highest site and direction down and
// reports the first entry whose cumulative rate exceeds
// floor(total * fraction / 100000). Every item gives one result item on
// rsp_ch carrying the total after the item.
// One item is worked on at a time; req_ch.ready is high only while idle.
// A write reads the old rate (S_WRD), updates the table and the total (S_WUPD)
// and emits (S_EMIT). A select waits in S_THR while the product unit forms
// total * fraction (one fraction bit a cycle), primes the table read
// (S_PRIME), then takes each table entry through the single scan adder, one
// rate per species, and emits once an entry hits or the scan ends. After reset
// both rate RAMs are swept to zero, one entry a cycle, over all the
// LATTICE_SIDE*LATTICE_SIDE*4 entries (16384 by default); no item is accepted
// meanwhile. A result waits in the output register while rsp_ch stalls; a new
// item may be accepted then, and its own result waits until that one is taken.
module rate_table_event_selector import rtes_pkg::*; #(
   parameter int LATTICE_SIDE = 64,
   parameter int RATE_BITS    = 32
) (
   input  logic           clock,
   input  logic           reset,
   rtes_req_if.sink       req_ch,
   rtes_rsp_if.source     rsp_ch
);

   localparam int COORD_W = $clog2(LATTICE_SIDE);
   localparam int DEPTH   = LATTICE_SIDE * LATTICE_SIDE * 4;
   localparam int AW      = $clog2(DEPTH);
   localparam int SW      = AW - 2;
   localparam int SRATE_W = RATE_BITS + FRAC_W;
   localparam int ACC_W   = RATE_BITS + AW + 1 + FRAC_W;
   localparam int CMP_W   = (ACC_W > PROD_W) ? ACC_W : PROD_W;

   localparam logic [2:0] S_CLR   = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_WRD   = 3'd2;
   localparam logic [2:0] S_WUPD  = 3'd3;
   localparam logic [2:0] S_THR   = 3'd4;
   localparam logic [2:0] S_PRIME = 3'd5;
   localparam logic [2:0] S_SCAN  = 3'd6;
   localparam logic [2:0] S_EMIT  = 3'd7;

   localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(LATTICE_SIDE - 1);
   localparam logic [AW-1:0]      IDX_MAX   = AW'(DEPTH - 1);

   // Control state
   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      clr_idx_ff, clr_idx_in;
   logic [SUM_W-1:0]   rate_sum_ff, rate_sum_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Item and scan registers
   logic [5:0]         sx_ff, sx_in;
   logic [5:0]         sy_ff, sy_in;
   logic [1:0]         dir_ff, dir_in;
   logic               species_ff, species_in;
   logic [RATE_BITS-1:0] value_ff, value_in;
   logic [AW-1:0]      scan_idx_ff, scan_idx_in;
   logic [COORD_W-1:0] scan_x_ff, scan_x_in;
   logic [COORD_W-1:0] scan_y_ff, scan_y_in;
   logic [1:0]         scan_d_ff, scan_d_in;
   logic               phase_ff, phase_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;

   // Pending result and output register
   logic [1:0]         res_kind_ff, res_kind_in;
   logic [COORD_W-1:0] res_x_ff, res_x_in;
   logic [COORD_W-1:0] res_y_ff, res_y_in;
   logic [1:0]         res_d_ff, res_d_in;
   logic [1:0]         out_kind_ff, out_kind_in;
   logic [5:0]         out_x_ff, out_x_in;
   logic [5:0]         out_y_ff, out_y_in;
   logic [1:0]         out_d_ff, out_d_in;
   logic [SUM_W-1:0]   out_total_ff, out_total_in;

   // RAM and product unit connections
   logic               int_wr_en, vac_wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [RATE_BITS-1:0] wr_data;
   logic [RATE_BITS-1:0] int_rd_data, vac_rd_data;
   logic               thr_start, thr_done;
   logic [PROD_W-1:0]  frac_product;

   // Helper signals
   logic               accept;
   logic               rsp_free;
   logic [SUM_W-1:0]   value_wide;
   logic [COORD_W+5:0] sx_wide, sy_wide;
   logic [SW-1:0]      wr_site;
   logic [AW-1:0]      wr_idx;
   logic               in_lattice;
   logic [RATE_BITS-1:0] old_rate;
   logic [RATE_BITS-1:0] scan_rate;
   logic [SRATE_W-1:0] scaled_rate;
   logic [ACC_W-1:0]   acc_sum;
   logic               hit;
   logic [COORD_W+5:0] res_x_wide, res_y_wide;

   assign accept   = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // Write address from the latched item: ((x * side) + y) * 4 + direction
   always_comb begin
      value_wide = {{(SUM_W-32){1'b0}}, req_ch.rate_value};
      sx_wide    = {{COORD_W{1'b0}}, sx_ff};
      sy_wide    = {{COORD_W{1'b0}}, sy_ff};
      in_lattice = (sx_wide < (COORD_W+6)'(LATTICE_SIDE))
                && (sy_wide < (COORD_W+6)'(LATTICE_SIDE));
      wr_site    = SW'(SW'(sx_wide[COORD_W-1:0]) * SW'(LATTICE_SIDE))
                 + SW'(sy_wide[COORD_W-1:0]);
      wr_idx     = {wr_site, dir_ff};
      old_rate   = (species_ff == SPECIES_VAC) ? vac_rd_data : int_rd_data;
   end

   // Scan adder: one rate per cycle, interstitial then vacancy of each entry.
   // The sum is kept scaled by 100000, so sum > floor(P / 100000) becomes
   // sum * 100000 > P with P = total * fraction.
   always_comb begin
      scan_rate   = phase_ff ? vac_rd_data : int_rd_data;
      scaled_rate = SRATE_W'(scan_rate) * SRATE_W'(FRAC_SCALE);
      acc_sum     = acc_ff + ACC_W'(scaled_rate);
      hit         = CMP_W'(acc_sum) > CMP_W'(frac_product);
   end

   // RAM ports
   always_comb begin
      int_wr_en = 1'b0;
      vac_wr_en = 1'b0;
      wr_addr   = wr_idx;
      wr_data   = value_ff;
      if (state_ff == S_CLR) begin
         int_wr_en = 1'b1;
         vac_wr_en = 1'b1;
         wr_addr   = clr_idx_ff;
         wr_data   = '0;
      end else if (state_ff == S_WUPD && in_lattice) begin
         int_wr_en = (species_ff == SPECIES_INT);
         vac_wr_en = (species_ff == SPECIES_VAC);
      end
      // the read address runs one entry ahead during the second half of an entry
      if (state_ff == S_SCAN && phase_ff) begin
         rd_addr = scan_idx_ff - 1'b1;
      end else if (state_ff == S_SCAN || state_ff == S_PRIME) begin
         rd_addr = scan_idx_ff;
      end else begin
         rd_addr = wr_idx;
      end
   end

   assign thr_start = accept && (req_ch.command == CMD_SELECT);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      rate_sum_in  = rate_sum_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      dir_in       = dir_ff;
      species_in   = species_ff;
      value_in     = value_ff;
      scan_idx_in  = scan_idx_ff;
      scan_x_in    = scan_x_ff;
      scan_y_in    = scan_y_ff;
      scan_d_in    = scan_d_ff;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      res_kind_in  = res_kind_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_d_in     = res_d_ff;
      unique case (state_ff)
         S_CLR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == IDX_MAX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               sx_in       = req_ch.site_x;
               sy_in       = req_ch.site_y;
               dir_in      = req_ch.direction;
               species_in  = req_ch.species;
               value_in    = value_wide[RATE_BITS-1:0];
               scan_idx_in = IDX_MAX;
               scan_x_in   = COORD_MAX;
               scan_y_in   = COORD_MAX;
               scan_d_in   = 2'd3;
               phase_in    = 1'b0;
               acc_in      = '0;
               res_kind_in = KIND_NONE;
               res_x_in    = '0;
               res_y_in    = '0;
               res_d_in    = '0;
               state_in    = (req_ch.command == CMD_WRITE) ? S_WRD : S_THR;
            end
         end
         S_WRD: begin
            state_in = S_WUPD;
         end
         S_WUPD: begin
            if (in_lattice) begin
               rate_sum_in = rate_sum_ff - SUM_W'(old_rate) + SUM_W'(value_ff);
            end
            state_in = S_EMIT;
         end
         S_THR: begin
            if (thr_done) begin
               state_in = S_PRIME;
            end
         end
         S_PRIME: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            acc_in = acc_sum;
            if (hit) begin
               res_kind_in = phase_ff ? KIND_VAC : KIND_INT;
               res_x_in    = scan_x_ff;
               res_y_in    = scan_y_ff;
               res_d_in    = scan_d_ff;
               state_in    = S_EMIT;
            end else if (phase_ff) begin
               phase_in = 1'b0;
               if (scan_idx_ff == '0) begin
                  state_in = S_EMIT;
               end else begin
                  scan_idx_in = scan_idx_ff - 1'b1;
                  if (scan_d_ff == 2'd0) begin
                     scan_d_in = 2'd3;
                     if (scan_y_ff == '0) begin
                        scan_y_in = COORD_MAX;
                        scan_x_in = scan_x_ff - 1'b1;
                     end else begin
                        scan_y_in = scan_y_ff - 1'b1;
                     end
                  end else begin
                     scan_d_in = scan_d_ff - 1'b1;
                  end
               end
            end else begin
               phase_in = 1'b1;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      res_x_wide   = {6'b0, res_x_ff};
      res_y_wide   = {6'b0, res_y_ff};
      out_kind_in  = out_kind_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_d_in     = out_d_ff;
      out_total_in = out_total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (state_ff == S_EMIT && rsp_free) begin
         rsp_valid_in = 1'b1;
         out_kind_in  = res_kind_ff;
         out_x_in     = res_x_wide[5:0];
         out_y_in     = res_y_wide[5:0];
         out_d_in     = res_d_ff;
         out_total_in = rate_sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_idx_ff   <= '0;
         rate_sum_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rate_sum_ff  <= rate_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      dir_ff       <= dir_in;
      species_ff   <= species_in;
      value_ff     <= value_in;
      scan_idx_ff  <= scan_idx_in;
      scan_x_ff    <= scan_x_in;
      scan_y_ff    <= scan_y_in;
      scan_d_ff    <= scan_d_in;
      phase_ff     <= phase_in;
      acc_ff       <= acc_in;
      res_kind_ff  <= res_kind_in;
      res_x_ff     <= res_x_in;
      res_y_ff     <= res_y_in;
      res_d_ff     <= res_d_in;
      out_kind_ff  <= out_kind_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_d_ff     <= out_d_in;
      out_total_ff <= out_total_in;
   end

   // Rate tables
   rtes_ram #(
      .WIDTH (RATE_BITS),
      .DEPTH (DEPTH)
   ) int_ram (
      .clock   (clock),
      .wr_en   (int_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (int_rd_data)
   );

   rtes_ram #(
      .WIDTH (RATE_BITS),
      .DEPTH (DEPTH)
   ) vac_ram (
      .clock   (clock),
      .wr_en   (vac_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (vac_rd_data)
   );

   // total * fraction from the total before this item
   rtes_thresh u_thresh (
      .clock   (clock),
      .reset   (reset),
      .start   (thr_start),
      .total   (rate_sum_ff),
      .frac    (req_ch.random_fraction),
      .done    (thr_done),
      .product (frac_product)
   );

   // Ports
   assign req_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.hop_kind      = out_kind_ff;
   assign rsp_ch.hop_x         = out_x_ff;
   assign rsp_ch.hop_y         = out_y_ff;
   assign rsp_ch.hop_direction = out_d_ff;
   assign rsp_ch.total_rate    = out_total_ff;

endmodule

### verif/rate_table_event_selector_test.sv
// Testbench for the rate-table event selector: random and directed items
// checked against a local table model.
module rate_table_event_selector_test import rtes_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int    SIDE         = 64;
   localparam int    DIRS         = 4;
   localparam int    TABLE_DEPTH  = SIDE * SIDE * DIRS;
   localparam int    PHASE_ITEMS  = 25;
   localparam int    SETTLE_CYCLES = 16;
   localparam longint LIMIT_CYCLES = 64'd20_000_000;

   typedef struct packed {
      logic              command;
      logic [5:0]        site_x;
      logic [5:0]        site_y;
      logic [1:0]        direction;
      logic              species;
      logic [31:0]       rate_value;
      logic [FRAC_W-1:0] random_fraction;
   } hop_request_type;

   typedef struct packed {
      logic [1:0]       hop_kind;
      logic [5:0]       hop_x;
      logic [5:0]       hop_y;
      logic [1:0]       hop_direction;
      logic [SUM_W-1:0] total_rate;
   } hop_result_type;

   // Keeps a copy of both rate tables and the queue of results still owed
   class hop_scoreboard_type;
      bit [31:0]      interstitial_rate [TABLE_DEPTH];
      bit [31:0]      vacancy_rate [TABLE_DEPTH];
      bit [SUM_W-1:0] rate_total;
      hop_result_type owed_results [$];
      int             failures;

      function new();
         rate_total = '0;
         failures   = 0;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      function void log_failure(string what, hop_result_type want, hop_result_type got);
         failures++;
         if (failures <= 10) begin
            $display("%s: expected kind %0d x %0d y %0d dir %0d total %0d,",
                     what, want.hop_kind, want.hop_x, want.hop_y, want.hop_direction,
                     want.total_rate);
            $display("   got kind %0d x %0d y %0d dir %0d total %0d",
                     got.hop_kind, got.hop_x, got.hop_y, got.hop_direction,
                     got.total_rate);
         end
      endfunction

      // Update the tables or pick a hop, then queue the result owed
      function void note_request(hop_request_type rq);
         hop_result_type res;
         int          idx;
         bit [64:0]   product;
         bit [64:0]   threshold;
         bit [63:0]   running;
         bit          found;
         res = '0;
         if (rq.command == CMD_WRITE) begin
            idx = (int'(rq.site_x) * SIDE + int'(rq.site_y)) * DIRS + int'(rq.direction);
            if (rq.species == SPECIES_VAC) begin
               rate_total = rate_total - vacancy_rate[idx] + rq.rate_value;
               vacancy_rate[idx] = rq.rate_value;
            end else begin
               rate_total = rate_total - interstitial_rate[idx] + rq.rate_value;
               interstitial_rate[idx] = rq.rate_value;
            end
         end else begin
            product   = 65'(rate_total) * 65'(rq.random_fraction);
            threshold = product / 65'(FRAC_SCALE);
            running   = '0;
            found     = 1'b0;
            // Scan from the top corner down, interstitial before vacancy
            for (int x = SIDE - 1; x >= 0 && !found; x--) begin
               for (int y = SIDE - 1; y >= 0 && !found; y--) begin
                  for (int k = DIRS - 1; k >= 0 && !found; k--) begin
                     idx = (x * SIDE + y) * DIRS + k;
                     running += interstitial_rate[idx];
                     if (running > threshold) begin
                        found = 1'b1;
                        res.hop_kind = KIND_INT;
                     end else begin
                        running += vacancy_rate[idx];
                        if (running > threshold) begin
                           found = 1'b1;
                           res.hop_kind = KIND_VAC;
                        end
                     end
                     if (found) begin
                        res.hop_x         = 6'(x);
                        res.hop_y         = 6'(y);
                        res.hop_direction = 2'(k);
                     end
                  end
               end
            end
         end
         res.total_rate = rate_total;
         owed_results.push_back(res);
      endfunction

      // Compare one result with the oldest one owed
      function void check_result(hop_result_type got);
         hop_result_type want;
         if (owed_results.size() == 0) begin
            log_failure("result with nothing outstanding", '0, got);
         end else begin
            want = owed_results.pop_front();
            if (got.hop_kind != want.hop_kind || got.hop_x != want.hop_x ||
                got.hop_y != want.hop_y || got.hop_direction != want.hop_direction ||
                got.total_rate != want.total_rate) begin
               log_failure("result mismatch", want, got);
            end
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   rtes_req_if         req_ch ();
   rtes_rsp_if         rsp_ch ();
   hop_scoreboard_type board;
   int                 sender_idle_pct;
   int                 receiver_stall_pct;
   longint             cycle_count;

   rate_table_event_selector #(
      .LATTICE_SIDE (SIDE),
      .RATE_BITS    (32)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Watch both channels for accepted items
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            board.note_request('{req_ch.command, req_ch.site_x, req_ch.site_y,
                                 req_ch.direction, req_ch.species, req_ch.rate_value,
                                 req_ch.random_fraction});
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            board.check_result('{rsp_ch.hop_kind, rsp_ch.hop_x, rsp_ch.hop_y,
                                 rsp_ch.hop_direction, rsp_ch.total_rate});
         end
      end
   end

   // Write item; unused fraction is noise
   function automatic hop_request_type rate_write(int x, int y, int d, logic sp,
                                                  logic [31:0] val);
      hop_request_type rq;
      rq.command         = CMD_WRITE;
      rq.site_x          = 6'(x);
      rq.site_y          = 6'(y);
      rq.direction       = 2'(d);
      rq.species         = sp;
      rq.rate_value      = val;
      rq.random_fraction = FRAC_W'($urandom_range(0, (1 << FRAC_W) - 1));
      return rq;
   endfunction

   // Select item; unused site fields are noise
   function automatic hop_request_type hop_select(int frac);
      hop_request_type rq;
      rq.command         = CMD_SELECT;
      rq.site_x          = 6'($urandom);
      rq.site_y          = 6'($urandom);
      rq.direction       = 2'($urandom);
      rq.species         = 1'($urandom);
      rq.rate_value      = $urandom;
      rq.random_fraction = FRAC_W'(frac);
      return rq;
   endfunction

   // Present one item after a random gap and hold it until accepted
   task automatic send_item(input hop_request_type rq);
      int gap;
      gap = 0;
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.command         <= rq.command;
      req_ch.site_x          <= rq.site_x;
      req_ch.site_y          <= rq.site_y;
      req_ch.direction       <= rq.direction;
      req_ch.species         <= rq.species;
      req_ch.rate_value      <= rq.rate_value;
      req_ch.random_fraction <= rq.random_fraction;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stop sending until every owed result has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      hop_request_type directed [$];
      hop_request_type rq;
      logic [31:0]     val;

      board              = new();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      reset                  <= 1'b1;
      req_ch.valid           <= 1'b0;
      req_ch.command         <= CMD_WRITE;
      req_ch.site_x          <= '0;
      req_ch.site_y          <= '0;
      req_ch.direction       <= '0;
      req_ch.species         <= SPECIES_INT;
      req_ch.rate_value      <= '0;
      req_ch.random_fraction <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty tables, first and last entries, both kinds, fraction limits
      directed.push_back(hop_select(0));
      directed.push_back(rate_write(63, 63, 3, SPECIES_INT, 32'd1));
      directed.push_back(hop_select(0));
      directed.push_back(rate_write(0, 0, 0, SPECIES_INT, 32'd5));
      directed.push_back(rate_write(0, 0, 0, SPECIES_VAC, 32'd7));
      directed.push_back(hop_select(40000));
      directed.push_back(hop_select(50000));
      directed.push_back(hop_select(99999));
      directed.push_back(hop_select(100000));
      directed.push_back(hop_select((1 << FRAC_W) - 1));
      // clear the far corner so later scans stay short
      directed.push_back(rate_write(0, 0, 0, SPECIES_INT, 32'd0));
      directed.push_back(rate_write(0, 0, 0, SPECIES_VAC, 32'd0));
      directed.push_back(rate_write(63, 63, 3, SPECIES_VAC, 32'hFFFF_FFFF));
      directed.push_back(rate_write(63, 0, 0, SPECIES_INT, 32'h8000_0000));
      directed.push_back(rate_write(62, 31, 2, SPECIES_INT, 32'h5555_5555));
      directed.push_back(rate_write(61, 42, 1, SPECIES_VAC, 32'hAAAA_AAAA));
      directed.push_back(hop_select(99999));
      directed.push_back(hop_select(50000));
      directed.push_back(rate_write(63, 63, 3, SPECIES_INT, 32'h0000_1234));
      directed.push_back(hop_select(1));
      directed.push_back(hop_select(65536));
      foreach (directed[i]) send_item(directed[i]);
      drain();

      // Random phases: free flow, idle sender, stalling receiver, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 78; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 78; end
            default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(1) == 0) begin
               case ($urandom_range(9))
                  0: val = 32'd0;
                  1: val = 32'hFFFF_FFFF;
                  default: val = $urandom;
               endcase
               // sites near the scan start keep select scans short
               rq = rate_write($urandom_range(60, 63), $urandom_range(0, 63),
                               $urandom_range(0, 3), 1'($urandom), val);
            end else if ($urandom_range(99) < 3) begin
               rq = hop_select($urandom_range(100000, (1 << FRAC_W) - 1));
            end else begin
               rq = hop_select($urandom_range(0, 99999));
            end
            send_item(rq);
         end
         drain();
      end

      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending() != 0) begin
         $display("%0d results never arrived", board.pending());
         board.failures += board.pending();
      end
      if (board.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### rate_table_event_selector.f
hw/rtl/rtes_pkg.sv
hw/rtl/rtes_req_if.sv
hw/rtl/rtes_rsp_if.sv
hw/rtl/rtes_ram.sv
hw/rtl/rtes_thresh.sv
hw/rtl/rate_table_event_selector.sv
verif/rate_table_event_selector_test.sv
